@@ rtl/core/comb_enum_pkg.sv @@
package comb_enum_pkg;

   localparam int unsigned REG_SET_SIZE     = 0;
   localparam int unsigned REG_CHOOSE_COUNT = 1;

   localparam logic [4:0] SET_SIZE_RESET     = 5'd16;
   localparam logic [4:0] CHOOSE_COUNT_RESET = 5'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_first;
      logic emit_init;
      logic scan_init;
      logic scan_step;
      logic apply_pivot;
      logic emit_step;
      logic out_load;
      logic out_empty;
   } cmd_type;

   typedef struct packed {
      logic started;
      logic n_lt2;
      logic k_zero;
      logic pivot_hit;
      logic p_zero;
      logic bit_q;
      logic q_at_end;
      logic last_hit;
      logic out_free;
   } status_type;

endpackage

@@ rtl/core/comb_enum_ctrl.sv @@
module comb_enum_ctrl
   import comb_enum_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_restart,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.emit_init = 1'b1;
               if (req_restart || !status.started || status.n_lt2) begin
                  cmd.load_first = 1'b1;
                  state_in       = ST_EMIT;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.pivot_hit) begin
               cmd.apply_pivot = 1'b1;
               state_in        = ST_EMIT;
            end else if (status.p_zero) begin
               cmd.load_first = 1'b1;
               state_in       = ST_EMIT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_EMIT: begin
            if (status.k_zero) begin
               if (status.out_free) begin
                  cmd.out_load  = 1'b1;
                  cmd.out_empty = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (status.bit_q) begin
               if (status.out_free) begin
                  cmd.out_load = 1'b1;
                  if (status.last_hit || status.q_at_end) begin
                     state_in = ST_IDLE;
                  end else begin
                     cmd.emit_step = 1'b1;
                  end
               end
            end else if (status.q_at_end) begin
               state_in = ST_IDLE;
            end else begin
               cmd.emit_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/comb_enum_dp.sv @@
module comb_enum_dp
   import comb_enum_pkg::*;
#(
   parameter int MAX_ELEMENTS = 16
)
(
   input  logic                                   clock,
   input  logic                                   reset,
   input  cmd_type                                cmd,
   input  logic                                   cfg_wr,
   input  logic [$clog2(MAX_ELEMENTS + 1) - 1:0]  n,
   input  logic [$clog2(MAX_ELEMENTS + 1) - 1:0]  k,
   output status_type                             status,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic [3:0]                             rsp_element_index,
   output logic                                   rsp_present,
   output logic                                   rsp_last_of_subset,
   output logic                                   rsp_final_subset
);

   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

   logic [MAX_ELEMENTS-1:0] mask_ff;
   logic [MAX_ELEMENTS-1:0] mask_in;
   logic [IW-1:0]           p_ff;
   logic [CW-1:0]           ones_ff;
   logic [IW-1:0]           q_ff;
   logic [CW-1:0]           seen_ff;
   logic                    started_ff;
   logic                    valid_ff;
   logic [3:0]              idx_ff;
   logic                    present_ff;
   logic                    last_ff;
   logic                    final_ff;

   logic [MAX_ELEMENTS:0]   mask_x;
   logic [CW-1:0]           p1;
   logic [IW-1:0]           n_last;
   logic [CW-1:0]           ones_tot;
   logic [CW-1:0]           n_minus_k;
   logic [MAX_ELEMENTS-1:0] first_mask;
   logic [MAX_ELEMENTS-1:0] pivot_mask;
   logic [MAX_ELEMENTS-1:0] fin_mask;
   logic                    out_free;

   assign mask_x    = {1'b0, mask_ff};
   assign p1        = CW'(p_ff) + 1'b1;
   assign n_last    = IW'(n - 1'b1);
   assign ones_tot  = ones_ff + 1'b1;
   assign n_minus_k = n - k;
   assign out_free  = !valid_ff || rsp_ready;

   always_comb begin
      for (int j = 0; j < MAX_ELEMENTS; j++) begin
         first_mask[j] = (CW + 1)'(j) < {1'b0, k};
         fin_mask[j]   = ((CW + 1)'(j) >= {1'b0, n_minus_k}) && ((CW + 1)'(j) < {1'b0, n});
         if ((CW + 1)'(j) < {1'b0, CW'(p_ff)}) begin
            pivot_mask[j] = mask_ff[j];
         end else if (((CW + 1)'(j) > {1'b0, CW'(p_ff)})
                      && ((CW + 1)'(j) <= ({1'b0, CW'(p_ff)} + {1'b0, ones_tot}))) begin
            pivot_mask[j] = 1'b1;
         end else begin
            pivot_mask[j] = 1'b0;
         end
      end
   end

   always_comb begin
      mask_in = mask_ff;
      if (cmd.load_first) begin
         mask_in = first_mask;
      end else if (cmd.apply_pivot) begin
         mask_in = pivot_mask;
      end
   end

   always_comb begin
      status.started   = started_ff;
      status.n_lt2     = n < CW'(2);
      status.k_zero    = k == '0;
      status.pivot_hit = (p_ff != n_last) && mask_ff[p_ff] && !mask_x[p1];
      status.p_zero    = p_ff == '0;
      status.bit_q     = mask_ff[q_ff];
      status.q_at_end  = q_ff == n_last;
      status.last_hit  = (seen_ff + 1'b1) == k;
      status.out_free  = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff    <= '0;
         started_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         if (cfg_wr) begin
            started_ff <= 1'b0;
         end else if (cmd.load_first) begin
            started_ff <= 1'b1;
         end
         if (cmd.out_load) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         p_ff    <= n_last;
         ones_ff <= '0;
      end else if (cmd.scan_step) begin
         p_ff    <= p_ff - 1'b1;
         ones_ff <= ones_ff + CW'(mask_ff[p_ff]);
      end
      if (cmd.emit_init) begin
         q_ff    <= '0;
         seen_ff <= '0;
      end else begin
         if (cmd.emit_step) begin
            q_ff <= q_ff + 1'b1;
         end
         if (cmd.out_load && !cmd.out_empty) begin
            seen_ff <= seen_ff + 1'b1;
         end
      end
      if (cmd.out_load) begin
         if (cmd.out_empty) begin
            idx_ff     <= 4'd0;
            present_ff <= 1'b0;
            last_ff    <= 1'b1;
            final_ff   <= 1'b1;
         end else begin
            idx_ff     <= 4'(q_ff);
            present_ff <= 1'b1;
            last_ff    <= (seen_ff + 1'b1) == k;
            final_ff   <= mask_ff == fin_mask;
         end
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_element_index  = idx_ff;
   assign rsp_present        = present_ff;
   assign rsp_last_of_subset = last_ff;
   assign rsp_final_subset   = final_ff;

endmodule

@@ rtl/core/combination_enumerator.sv @@
// Channel   Ports                                       Direction
// req       req_valid, req_ready, req_restart           in
// rsp       rsp_valid, rsp_ready, rsp_element_index,    out
//           rsp_present, rsp_last_of_subset, rsp_final_subset
// csr       psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One request transaction is taken at a time, from the idle state.
// Advance scans the mask from the last position down, one bit per cycle, and then
// the index sweep steps through the mask positions up to the last member.
// A stalled rsp transaction holds the sweep at the current member.
// Synchronous reset clears the state machine, the mask, and the output valid.
module combination_enumerator
   import comb_enum_pkg::*;
#(
   parameter int MAX_ELEMENTS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_element_index,
   output logic        rsp_present,
   output logic        rsp_last_of_subset,
   output logic        rsp_final_subset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int XW = (CW > 5) ? CW : 5;

   logic [4:0]    set_size_ff;
   logic [4:0]    choose_count_ff;
   logic          cfg_wr;
   logic [XW-1:0] ss_x;
   logic [XW-1:0] cc_x;
   logic [XW-1:0] n_x;
   logic [CW-1:0] n_eff;
   logic [CW-1:0] k_eff;
   cmd_type       cmd;
   status_type    status;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff     <= SET_SIZE_RESET;
         choose_count_ff <= CHOOSE_COUNT_RESET;
      end else if (cfg_wr) begin
         if (paddr[2] == 1'(REG_CHOOSE_COUNT)) begin
            choose_count_ff <= pwdata[4:0];
         end else begin
            set_size_ff <= pwdata[4:0];
         end
      end
   end

   assign prdata = (paddr[2] == 1'(REG_CHOOSE_COUNT)) ? {27'd0, choose_count_ff}
                                                     : {27'd0, set_size_ff};

   assign ss_x = XW'(set_size_ff);
   assign cc_x = XW'(choose_count_ff);

   always_comb begin
      if (ss_x == '0) begin
         n_x = XW'(1);
      end else if (ss_x > XW'(MAX_ELEMENTS)) begin
         n_x = XW'(MAX_ELEMENTS);
      end else begin
         n_x = ss_x;
      end
   end

   assign n_eff = CW'(n_x);
   assign k_eff = (cc_x > n_x) ? CW'(n_x) : CW'(cc_x);

   comb_enum_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_ready   (req_ready),
      .status      (status),
      .cmd         (cmd)
   );

   comb_enum_dp #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cfg_wr             (cfg_wr),
      .n                  (n_eff),
      .k                  (k_eff),
      .status             (status),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_element_index  (rsp_element_index),
      .rsp_present        (rsp_present),
      .rsp_last_of_subset (rsp_last_of_subset),
      .rsp_final_subset   (rsp_final_subset)
   );

endmodule

@@ tb/combination_enumerator_checker.sv @@
`timescale 1ns / 1ps

module combination_enumerator_checker
   import comb_enum_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_restart,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_element_index,
   input  logic        rsp_present,
   input  logic        rsp_last_of_subset,
   input  logic        rsp_final_subset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count
);

   localparam int MAX_MEMBERS = 16;

   typedef struct packed {
      logic [3:0] element_index;
      logic       present;
      logic       last_of_subset;
      logic       final_subset;
   } member_type;

   member_type  expected_members[$];
   member_type  want;
   logic [4:0]  set_size_q;
   logic [4:0]  choose_count_q;
   logic [15:0] subset_mask_q;
   logic        started_q;
   logic [31:0] reg_value;
   int          mismatches;
   int          compared;

   function automatic int effective_n();
      int n;
      n = set_size_q;
      if (n < 1) n = 1;
      if (n > MAX_MEMBERS) n = MAX_MEMBERS;
      return n;
   endfunction

   function automatic int effective_k(int n);
      int k;
      k = choose_count_q;
      if (k > n) k = n;
      return k;
   endfunction

   function automatic logic [15:0] first_subset_mask(int k);
      logic [15:0] m;
      m = '0;
      for (int i = 0; i < k; i++) m[i] = 1'b1;
      return m;
   endfunction

   function automatic logic [15:0] final_subset_mask(int n, int k);
      logic [15:0] m;
      m = '0;
      for (int i = n - k; i < n; i++) m[i] = 1'b1;
      return m;
   endfunction

   // next smaller pattern with the same popcount, index 0 most significant
   function automatic logic [15:0] next_subset_mask(logic [15:0] m, int n, int k);
      int          ones;
      logic [15:0] r;
      if (n < 2) return first_subset_mask(k);
      for (int i = n - 2; i >= 0; i--) begin
         if (m[i] && !m[i + 1]) begin
            ones = 1;
            for (int j = i + 1; j < n; j++) if (m[j]) ones++;
            r = '0;
            for (int j = 0; j < i; j++) r[j] = m[j];
            for (int j = i + 1; j < n && j <= i + ones; j++) r[j] = 1'b1;
            return r;
         end
      end
      return first_subset_mask(k);
   endfunction

   task automatic predict_subset(input logic restart);
      int         n;
      int         k;
      int         seen;
      logic       fin;
      member_type m;
      n = effective_n();
      k = effective_k(n);
      if (restart || !started_q) subset_mask_q = first_subset_mask(k);
      else subset_mask_q = next_subset_mask(subset_mask_q, n, k);
      started_q = 1'b1;
      fin = (subset_mask_q == final_subset_mask(n, k));
      if (k == 0) begin
         m = '{element_index: 4'd0, present: 1'b0, last_of_subset: 1'b1, final_subset: 1'b1};
         expected_members.insert(expected_members.size(), m);
      end else begin
         seen = 0;
         for (int i = 0; i < n; i++) begin
            if (subset_mask_q[i]) begin
               seen++;
               m.element_index  = 4'(i);
               m.present        = 1'b1;
               m.last_of_subset = (seen == k);
               m.final_subset   = fin;
               expected_members.insert(expected_members.size(), m);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         set_size_q     = SET_SIZE_RESET;
         choose_count_q = CHOOSE_COUNT_RESET;
         subset_mask_q  = '0;
         started_q      = 1'b0;
         expected_members.delete();
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr == 3'(REG_SET_SIZE * 4)) begin
                  set_size_q = pwdata[4:0];
                  started_q  = 1'b0;
               end else if (paddr == 3'(REG_CHOOSE_COUNT * 4)) begin
                  choose_count_q = pwdata[4:0];
                  started_q      = 1'b0;
               end
            end else if (paddr == 3'(REG_SET_SIZE * 4) ||
                         paddr == 3'(REG_CHOOSE_COUNT * 4)) begin
               reg_value = (paddr == 3'(REG_SET_SIZE * 4)) ?
                           {27'd0, set_size_q} : {27'd0, choose_count_q};
               if (prdata !== reg_value) begin
                  $error("prdata at 0x%0h expected %0d got %0d", paddr, reg_value, prdata);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) predict_subset(req_restart);
         if (rsp_valid && rsp_ready) begin
            if (expected_members.size() == 0) begin
               $error("result with no transaction pending: element_index %0d",
                      rsp_element_index);
               mismatches++;
            end else begin
               want = expected_members.pop_front();
               compared++;
               if (rsp_element_index !== want.element_index) begin
                  $error("element_index expected %0d got %0d",
                         want.element_index, rsp_element_index);
                  mismatches++;
               end
               if (rsp_present !== want.present) begin
                  $error("present expected %0d got %0d", want.present, rsp_present);
                  mismatches++;
               end
               if (rsp_last_of_subset !== want.last_of_subset) begin
                  $error("last_of_subset expected %0d got %0d",
                         want.last_of_subset, rsp_last_of_subset);
                  mismatches++;
               end
               if (rsp_final_subset !== want.final_subset) begin
                  $error("final_subset expected %0d got %0d",
                         want.final_subset, rsp_final_subset);
                  mismatches++;
               end
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_members.size();
      checked_count <= compared;
   end

endmodule

@@ tb/tb_combination_enumerator.sv @@
`timescale 1ns / 1ps

module tb_combination_enumerator;
   import comb_enum_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_restart;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_element_index;
   logic        rsp_present;
   logic        rsp_last_of_subset;
   logic        rsp_final_subset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int fail_count;
   int pending_count;
   int checked_count;
   int snd_idle_pct;
   int rcv_idle_pct;
   int rsp_hold_request;
   int hold_left;
   int requests_sent;
   int settings_count;

   combination_enumerator DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_element_index  (rsp_element_index),
      .rsp_present        (rsp_present),
      .rsp_last_of_subset (rsp_last_of_subset),
      .rsp_final_subset   (rsp_final_subset),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   combination_enumerator_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_element_index  (rsp_element_index),
      .rsp_present        (rsp_present),
      .rsp_last_of_subset (rsp_last_of_subset),
      .rsp_final_subset   (rsp_final_subset),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .checked_count      (checked_count)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // receiver: random stalls, plus long hold-offs on request
   always @(negedge clock) begin
      if (rsp_hold_request > 0) begin
         hold_left        = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   task automatic send_request(input logic restart);
      @(negedge clock);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // write, then read back
   task automatic write_reg(input int index, input logic [4:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(index * 4);
      pwdata  <= {27'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic configure(input logic [4:0] n, input logic [4:0] k, input int which);
      wait_drained();
      if (which != 2) write_reg(REG_SET_SIZE, n);
      if (which != 1) write_reg(REG_CHOOSE_COUNT, k);
      settings_count++;
   endtask

   task automatic send_burst(input int count, input int restart_pct);
      for (int i = 0; i < count; i++) send_request($urandom_range(99) < restart_pct);
   endtask

   task automatic run_phase(input int snd_pct, input int rcv_pct, input int target,
                            input bit with_hold);
      int          sent;
      int          pick;
      int          n_eff;
      logic [4:0]  n;
      logic [4:0]  k;
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      sent = 0;
      while (sent < target) begin
         pick = $urandom_range(99);
         if (pick < 70) n = 5'($urandom_range(1, 8));
         else if (pick < 90) n = 5'($urandom_range(9, 16));
         else n = 5'($urandom_range(0, 31));
         n_eff = (n == 0) ? 1 : (n > 16) ? 16 : n;
         if ($urandom_range(99) < 80) k = 5'($urandom_range(0, n_eff));
         else k = 5'($urandom_range(0, 31));
         configure(n, k, (settings_count < 4) ? 0 : $urandom_range(2));
         pick = $urandom_range(4, 24);
         send_burst(pick, 8);
         sent += pick;
      end
      if (with_hold) begin
         wait_drained();
         rsp_hold_request = 400;
         send_burst(10, 8);
         wait_drained();
         send_burst(6, 0);
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_restart      = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      rsp_ready        = 1'b0;
      snd_idle_pct     = 26;
      rcv_idle_pct     = 66;
      rsp_hold_request = 0;
      hold_left        = 0;
      requests_sent    = 0;
      settings_count   = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset sizes: first request loads regardless of restart
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      // full walk with final subset and wrap
      configure(5'd4, 5'd2, 0);
      send_burst(7, 0);
      // empty subset
      configure(5'd5, 5'd0, 0);
      send_request(1'b0);
      send_request(1'b1);
      // k equal to n
      configure(5'd3, 5'd3, 0);
      send_burst(2, 0);
      // n of zero, k above n
      configure(5'd0, 5'd31, 0);
      send_burst(2, 0);
      // n above the maximum, all members
      configure(5'd31, 5'd16, 0);
      send_request(1'b0);
      configure(5'd16, 5'd15, 0);
      send_request(1'b0);
      send_request(1'b0);
      send_request(1'b1);
      configure(5'd1, 5'd0, 0);
      send_request(1'b0);
      configure(5'd2, 5'd1, 0);
      send_burst(3, 0);

      run_phase(26, 66, 72, 1'b0);
      run_phase(66, 26, 72, 1'b0);
      run_phase(0, 0, 72, 1'b1);

      wait_drained();
      repeat (64) @(posedge clock);
      $display("Sent %0d requests over %0d register settings; %0d results checked.",
               requests_sent, settings_count, checked_count);
      $display("Covered empty and full subsets, clamped sizes, wraps, restarts and stalls.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
